// ----- hdl/cau_pkg.sv -----
// Package for the complex arithmetic unit.
// Holds the command and status codes, default widths and the control word
// that travels with each item. No dependencies.
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  typedef struct packed {
    logic valid;
    logic is_div;
    logic div_zero;
    logic neg_re;
    logic neg_im;
  } ctl_t;

endpackage

// ----- hdl/cau_front.sv -----
// Front end of the complex arithmetic unit: input register, products,
// sums and sign/magnitude split. Depends on cau_pkg.
module cau_front #(
  parameter int W = cau_pkg::DATA_WIDTH_DEF,
  parameter int F = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  cau_pkg::cmd_t       cmd,
  input  logic signed [W-1:0] a_re,
  input  logic signed [W-1:0] a_im,
  input  logic signed [W-1:0] b_re,
  input  logic signed [W-1:0] b_im,
  output cau_pkg::ctl_t       ctl,
  output logic [2*W-1:0]      mag_re,
  output logic [2*W-1:0]      mag_im,
  output logic [2*W-1:0]      den
);
  import cau_pkg::*;

  localparam int PW = 2 * W;

  logic                v1, v2, v3;
  cmd_t                cmd1, cmd2, cmd3;
  logic signed [W-1:0] ar1, ai1, br1, bi1;
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [W:0]   as_re2, as_im2;
  logic                dz2, dz3;
  logic signed [PW:0]  sre3, sim3, sre_next, sim_next;
  logic [PW-1:0]       den3;
  logic signed [W:0]   ar_x, ai_x, br_x, bi_x;
  logic signed [PW:0]  abs_re, abs_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ctl <= '0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      ctl.valid    <= v3;
      ctl.is_div   <= (cmd3 == CMD_DIV);
      ctl.div_zero <= dz3 && (cmd3 == CMD_DIV);
      ctl.neg_re   <= sre3[PW];
      ctl.neg_im   <= sim3[PW];
    end
  end

  assign ar_x = (W+1)'(ar1);
  assign ai_x = (W+1)'(ai1);
  assign br_x = (W+1)'(br1);
  assign bi_x = (W+1)'(bi1);

  always_ff @(posedge clk) begin
    cmd1 <= cmd;
    ar1  <= a_re;
    ai1  <= a_im;
    br1  <= b_re;
    bi1  <= b_im;
    cmd2 <= cmd1;
    p0   <= PW'(ar1) * PW'(br1);
    p1   <= PW'(ai1) * PW'(bi1);
    p2   <= PW'(ar1) * PW'(bi1);
    p3   <= PW'(ai1) * PW'(br1);
    p4   <= PW'(br1) * PW'(br1);
    p5   <= PW'(bi1) * PW'(bi1);
    as_re2 <= (cmd1 == CMD_SUB) ? ar_x - br_x : ar_x + br_x;
    as_im2 <= (cmd1 == CMD_SUB) ? ai_x - bi_x : ai_x + bi_x;
    dz2  <= (br1 == '0) && (bi1 == '0);
    cmd3 <= cmd2;
    dz3  <= dz2;
    sre3 <= sre_next;
    sim3 <= sim_next;
    den3 <= $unsigned(p4) + $unsigned(p5);
  end

  always_comb begin
    case (cmd2)
      CMD_ADD, CMD_SUB: begin
        sre_next = (PW+1)'(as_re2);
        sim_next = (PW+1)'(as_im2);
      end
      CMD_MUL: begin
        sre_next = (PW+1)'(p0) - (PW+1)'(p1);
        sim_next = (PW+1)'(p2) + (PW+1)'(p3);
      end
      default: begin
        sre_next = (PW+1)'(p0) + (PW+1)'(p1);
        sim_next = (PW+1)'(p3) - (PW+1)'(p2);
      end
    endcase
  end

  assign abs_re = sre3[PW] ? -sre3 : sre3;
  assign abs_im = sim3[PW] ? -sim3 : sim3;

  always_ff @(posedge clk) begin
    den <= den3;
    if (cmd3 == CMD_MUL) begin
      mag_re <= abs_re[PW-1:0] >> F;
      mag_im <= abs_im[PW-1:0] >> F;
    end else begin
      mag_re <= abs_re[PW-1:0];
      mag_im <= abs_im[PW-1:0];
    end
  end

endmodule

// ----- hdl/cau_div_lane.sv -----
// One lane of the pipelined restoring divider: overflow check at entry,
// then one quotient bit per stage. Depends on cau_pkg.
module cau_div_lane #(
  parameter int W = cau_pkg::DATA_WIDTH_DEF,
  parameter int F = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  div_in,
  input  logic [2*W-1:0]        mag_in,
  input  logic [2*W-1:0]        den_in,
  input  logic [W-1:0]          div_pipe,
  input  logic [W-1:0][2*W-1:0] den_pipe,
  output logic [W-1:0]          q_out,
  output logic                  ovf_out
);
  import cau_pkg::*;

  localparam int PW = 2 * W;
  localparam int NW = 2 * W + F;

  logic [PW-1:0] r   [0:W];
  logic [W-1:0]  n   [0:W];
  logic [W-1:0]  q   [0:W];
  logic          ovf [0:W];
  logic [NW-1:0] nfull, hi;

  assign nfull = NW'(mag_in) << F;
  assign hi    = nfull >> W;

  always_ff @(posedge clk) begin
    if (div_in) begin
      r[0]   <= hi[PW-1:0];
      n[0]   <= nfull[W-1:0];
      q[0]   <= '0;
      ovf[0] <= (hi >= NW'(den_in));
    end else begin
      r[0]   <= '0;
      n[0]   <= '0;
      q[0]   <= mag_in[W-1:0];
      ovf[0] <= ((mag_in >> W) != '0);
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [PW:0] t;
    logic        ge;
    assign t  = {r[k], n[k][W-1]};
    assign ge = (t >= {1'b0, den_pipe[k]});

    always_ff @(posedge clk) begin
      ovf[k+1] <= ovf[k];
      if (div_pipe[k]) begin
        r[k+1] <= ge ? PW'(t - {1'b0, den_pipe[k]}) : t[PW-1:0];
        n[k+1] <= n[k] << 1;
        q[k+1] <= {q[k][W-2:0], ge};
      end else begin
        r[k+1] <= r[k];
        n[k+1] <= n[k];
        q[k+1] <= q[k];
      end
    end
  end

  assign q_out   = q[W];
  assign ovf_out = ovf[W];

endmodule

// ----- hdl/cau_divider.sv -----
// Divider section: control and divisor pipeline around two divider lanes
// for the real and imaginary parts. Depends on cau_pkg and cau_div_lane.
module cau_divider #(
  parameter int W = cau_pkg::DATA_WIDTH_DEF,
  parameter int F = cau_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  cau_pkg::ctl_t  ctl_in,
  input  logic [2*W-1:0] mag_re,
  input  logic [2*W-1:0] mag_im,
  input  logic [2*W-1:0] den,
  output cau_pkg::ctl_t  ctl_out,
  output logic [W-1:0]   q_re,
  output logic [W-1:0]   q_im,
  output logic           ovf_re,
  output logic           ovf_im
);
  import cau_pkg::*;

  localparam int PW = 2 * W;

  ctl_t                 ctl_q [0:W];
  logic [W-1:0][PW-1:0] den_q;
  logic [W-1:0]         div_pipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q[0] <= '0;
    end else begin
      ctl_q[0] <= ctl_in;
    end
    den_q[0] <= den;
  end

  for (genvar k = 0; k < W; k++) begin : g_ctl
    assign div_pipe[k] = ctl_q[k].is_div;
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[k+1] <= '0;
      end else begin
        ctl_q[k+1] <= ctl_q[k];
      end
    end
    if (k < W - 1) begin : g_den
      always_ff @(posedge clk) begin
        den_q[k+1] <= den_q[k];
      end
    end
  end

  cau_div_lane #(.W(W), .F(F)) u_lane_re (
    .clk(clk), .div_in(ctl_in.is_div), .mag_in(mag_re), .den_in(den),
    .div_pipe(div_pipe), .den_pipe(den_q), .q_out(q_re), .ovf_out(ovf_re)
  );

  cau_div_lane #(.W(W), .F(F)) u_lane_im (
    .clk(clk), .div_in(ctl_in.is_div), .mag_in(mag_im), .den_in(den),
    .div_pipe(div_pipe), .den_pipe(den_q), .q_out(q_im), .ovf_out(ovf_im)
  );

  assign ctl_out = ctl_q[W];

endmodule

// ----- hdl/complex_arithmetic_unit.sv -----
// Complex arithmetic unit: add, subtract, multiply and divide of two complex
// Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS operands with saturation.
// Depends on cau_pkg, cau_front and cau_divider.
//
// Usage:
//   Drive cmd, a_re, a_im, b_re, b_im and raise start; the item is taken at
//   the rising edge where start is high and busy is low. busy is low at all
//   times outside reset, so one item can be taken every cycle.
//   Each item gives one result on res_re, res_im and status, shown for one
//   cycle with done high. Results leave in the order the items came in.
//   Every command passes through the whole pipeline, so each takes equally
//   long from the accepting edge to the edge that ends its done cycle.
//   The depth is set by the restoring divider, one quotient bit per stage.
//   Throughput: one item per cycle.
//   status: ok, divide by zero (results zero), or saturated.
//   Reset (rst, synchronous) empties the pipeline; items in flight are lost
//   and busy is high while rst is high.
//   The receiver cannot hold results off; done is never delayed.
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd,
  input  logic signed [DATA_WIDTH-1:0] a_re,
  input  logic signed [DATA_WIDTH-1:0] a_im,
  input  logic signed [DATA_WIDTH-1:0] b_re,
  input  logic signed [DATA_WIDTH-1:0] b_im,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] res_re,
  output logic signed [DATA_WIDTH-1:0] res_im,
  output logic [1:0]                   status
);
  import cau_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int PW  = 2 * W;
  localparam int LAT = W + 6;

  ctl_t          ctl_f, ctl_d;
  logic [PW-1:0] mag_re, mag_im, den;
  logic [W-1:0]  q_re, q_im, lim_re, lim_im, v_re, v_im;
  logic          ovf_re, ovf_im, sat_re, sat_im;
  status_t       status_q;

  assign busy = rst;

  cau_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .cmd(cmd_t'(cmd)),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .ctl(ctl_f), .mag_re(mag_re), .mag_im(mag_im), .den(den)
  );

  cau_divider #(.W(W), .F(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .ctl_in(ctl_f), .mag_re(mag_re), .mag_im(mag_im),
    .den(den), .ctl_out(ctl_d), .q_re(q_re), .q_im(q_im),
    .ovf_re(ovf_re), .ovf_im(ovf_im)
  );

  assign lim_re = ctl_d.neg_re ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign lim_im = ctl_d.neg_im ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign sat_re = ovf_re || (q_re > lim_re);
  assign sat_im = ovf_im || (q_im > lim_im);
  assign v_re   = sat_re ? lim_re : q_re;
  assign v_im   = sat_im ? lim_im : q_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_d.valid;
    end
    if (ctl_d.div_zero) begin
      res_re   <= '0;
      res_im   <= '0;
      status_q <= ST_DIV_ZERO;
    end else begin
      res_re   <= ctl_d.neg_re ? -v_re : v_re;
      res_im   <= ctl_d.neg_im ? -v_im : v_im;
      status_q <= (sat_re || sat_im) ? ST_SAT : ST_OK;
    end
  end

  assign status = status_q;

`ifndef ASSERT_OFF
  a_lat_valid : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted item gave no result");

  a_lat_empty : assert property (@(posedge clk) disable iff (rst)
    !start |-> ##LAT !done)
    else $error("result without an item");

  a_dz_zero : assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_DIV_ZERO) |-> (res_re == '0 && res_im == '0))
    else $error("divide by zero result not cleared");

  a_sat_lim : assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_SAT) |->
      (res_re == {1'b1, {(W-1){1'b0}}} || res_re == {1'b0, {(W-1){1'b1}}} ||
       res_im == {1'b1, {(W-1){1'b0}}} || res_im == {1'b0, {(W-1){1'b1}}}))
    else $error("saturated status without a limit value");
`endif

endmodule

// ----- tb/sv/complex_arithmetic_unit_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the complex arithmetic unit: watches accepted items and
// done strobes, computes expected results and compares them field by field.
// Depends on cau_pkg.
module complex_arithmetic_unit_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          cmd,
  input  logic signed [31:0]  a_re,
  input  logic signed [31:0]  a_im,
  input  logic signed [31:0]  b_re,
  input  logic signed [31:0]  b_im,
  input  logic                done,
  input  logic signed [31:0]  res_re,
  input  logic signed [31:0]  res_im,
  input  logic [1:0]          status,
  output int                  failures,
  output int                  pending,
  output int                  results_seen,
  output int                  saturated_seen,
  output int                  div_zero_seen
);
  import cau_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    status_t            st;
  } cplx_result_t;

  cplx_result_t expected_results[$];

  function automatic logic signed [129:0] shift_trunc(input logic signed [129:0] x);
    if (x < 0) return -((-x) >>> FRAC);
    return x >>> FRAC;
  endfunction

  function automatic logic signed [129:0] div_trunc(input logic signed [129:0] num,
                                                    input logic signed [129:0] den);
    logic signed [129:0] q;
    q = ((num < 0 ? -num : num) <<< FRAC) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic logic signed [31:0] saturate(input logic signed [129:0] x,
                                                  inout logic clipped);
    if (x > 130'sd2147483647) begin
      clipped = 1'b1;
      return 32'sh7fffffff;
    end
    if (x < -130'sd2147483648) begin
      clipped = 1'b1;
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic cplx_result_t compute_complex(input logic [1:0] c,
      input logic signed [31:0] ar, input logic signed [31:0] ai,
      input logic signed [31:0] br, input logic signed [31:0] bi);
    logic signed [129:0] x, y, den, ar_w, ai_w, br_w, bi_w;
    logic clipped;
    cplx_result_t r;
    ar_w = ar; ai_w = ai; br_w = br; bi_w = bi;
    clipped = 1'b0;
    case (cmd_t'(c))
      CMD_ADD: begin
        x = ar_w + br_w;
        y = ai_w + bi_w;
      end
      CMD_SUB: begin
        x = ar_w - br_w;
        y = ai_w - bi_w;
      end
      CMD_MUL: begin
        x = shift_trunc(ar_w * br_w - ai_w * bi_w);
        y = shift_trunc(ar_w * bi_w + ai_w * br_w);
      end
      default: begin
        if (br == 0 && bi == 0) begin
          r.re = '0;
          r.im = '0;
          r.st = ST_DIV_ZERO;
          return r;
        end
        den = br_w * br_w + bi_w * bi_w;
        x = div_trunc(br_w * ar_w + bi_w * ai_w, den);
        y = div_trunc(br_w * ai_w - bi_w * ar_w, den);
      end
    endcase
    r.re = saturate(x, clipped);
    r.im = saturate(y, clipped);
    r.st = clipped ? ST_SAT : ST_OK;
    return r;
  endfunction

  assign pending = expected_results.size();

  initial begin
    failures = 0;
    results_seen = 0;
    saturated_seen = 0;
    div_zero_seen = 0;
  end

  always @(posedge clk) begin
    cplx_result_t e;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: re=%0d im=%0d status=%0d",
               res_re, res_im, status);
        failures++;
      end else begin
        e = expected_results.pop_front();
        if (e.st == ST_SAT) saturated_seen++;
        if (e.st == ST_DIV_ZERO) div_zero_seen++;
        if (res_re !== e.re) begin
          $error("res_re: expected %0d, actual %0d", e.re, res_re);
          failures++;
        end
        if (res_im !== e.im) begin
          $error("res_im: expected %0d, actual %0d", e.im, res_im);
          failures++;
        end
        if (status !== e.st) begin
          $error("status: expected %0d, actual %0d", e.st, status);
          failures++;
        end
      end
    end
    if (!rst && start && !busy)
      expected_results.push_back(compute_complex(cmd, a_re, a_im, b_re, b_im));
  end
endmodule

// ----- tb/sv/complex_arithmetic_unit_test.sv -----
`timescale 1ns / 100ps
// Top of the complex arithmetic unit testbench: clock, reset, directed and
// random items with sender gaps, and the verdict.
// Depends on cau_pkg, complex_arithmetic_unit and complex_arithmetic_unit_checker.
module complex_arithmetic_unit_test;
  import cau_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 1580;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] cmd = CMD_ADD;
  logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic busy, done;
  logic signed [31:0] res_re, res_im;
  logic [1:0] status;
  int failures, pending, results_seen, saturated_seen, div_zero_seen;
  int gap_pct;
  int cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  complex_arithmetic_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .done(done), .res_re(res_re), .res_im(res_im), .status(status)
  );

  complex_arithmetic_unit_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .done(done), .res_re(res_re), .res_im(res_im), .status(status),
    .failures(failures), .pending(pending), .results_seen(results_seen),
    .saturated_seen(saturated_seen), .div_zero_seen(div_zero_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("complex_arithmetic_unit regression: fail");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(input cmd_t c, input logic signed [31:0] ar,
                       input logic signed [31:0] ai, input logic signed [31:0] br,
                       input logic signed [31:0] bi);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3, 4: return $signed($urandom());
      5: return $signed($urandom_range(65535) << 8) - 32'sd8388608;
      6: return $signed($urandom_range(1 << 20)) - 32'sd524288;
      7: return ($urandom_range(1) ? 32'sd65536 : -32'sd65536) * $urandom_range(8);
      default: return $signed($urandom_range(255)) - 32'sd128;
    endcase
  endfunction

  initial begin
    logic signed [31:0] br, bi;
    gap_pct = 7;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    issue(CMD_ADD, 32'sh7fffffff, 32'sh80000000, 32'sd1, -32'sd1);
    issue(CMD_ADD, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    issue(CMD_ADD, 32'sd65536, -32'sd3, 32'sd2, 32'sd3);
    issue(CMD_SUB, 32'sh80000000, 32'sh7fffffff, 32'sd1, -32'sd1);
    issue(CMD_SUB, '0, '0, 32'sh80000000, 32'sh7fffffff);
    issue(CMD_SUB, 32'sd100, -32'sd100, 32'sd50, 32'sd25);
    issue(CMD_MUL, 32'sd65536, '0, 32'sd65536, '0);
    issue(CMD_MUL, 32'sd65536, 32'sd65536, 32'sd65536, -32'sd65536);
    issue(CMD_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd1);
    issue(CMD_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    issue(CMD_MUL, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    issue(CMD_MUL, -32'sd3, 32'sd7, 32'sd5, -32'sd11);
    issue(CMD_DIV, 32'sd65536, 32'sd65536, '0, '0);
    issue(CMD_DIV, 32'sh80000000, 32'sh7fffffff, '0, '0);
    issue(CMD_DIV, 32'sd196608, -32'sd65536, 32'sd65536, '0);
    issue(CMD_DIV, 32'sd65536, '0, 32'sd196608, '0);
    issue(CMD_DIV, -32'sd65536, '0, 32'sd196608, '0);
    issue(CMD_DIV, 32'sh7fffffff, 32'sh80000000, 32'sd1, '0);
    issue(CMD_DIV, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    issue(CMD_DIV, 32'sd1, 32'sd1, 32'sh7fffffff, 32'sh80000000);
    issue(CMD_DIV, 32'sh80000000, '0, -32'sd65536, '0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) gap_pct = 53;
      if (i == 2 * RANDOM_ITEMS / 3) gap_pct = 0;
      if (i % 200 < 10) gap_pct = gap_pct;
      br = pick_operand();
      bi = pick_operand();
      if ($urandom_range(19) == 0) begin
        br = '0;
        bi = '0;
      end
      issue(cmd_t'($urandom_range(3)), pick_operand(), pick_operand(), br, bi);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    $display("covered %0d results of all four commands, %0d saturated, %0d divide by zero",
             results_seen, saturated_seen, div_zero_seen);
    $display("sender gaps at 7 and 53 percent and back to back");
    if (failures == 0) begin
      $display("complex_arithmetic_unit regression: pass");
    end else begin
      $display("complex_arithmetic_unit regression: fail");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/cau_pkg.sv
hdl/cau_front.sv
hdl/cau_div_lane.sv
hdl/cau_divider.sv
hdl/complex_arithmetic_unit.sv
tb/sv/complex_arithmetic_unit_checker.sv
tb/sv/complex_arithmetic_unit_test.sv
